// ===== design/ctsd_pkg.sv =====
// Shared types, constants and the suffix matcher for the code token shape detector.
package ctsd_pkg;

  localparam int unsigned MAX_QUERY_CHARS = 1023;
  localparam int unsigned CHARS_W         = $clog2(MAX_QUERY_CHARS + 1);
  localparam int unsigned SUFFIX_CHARS    = 5;
  localparam int unsigned TAIL_W          = 8 * SUFFIX_CHARS;
  localparam int unsigned EXT_COUNT       = 15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Extensions right-aligned: last character of the extension in the low byte.
  localparam logic [TAIL_W-1:0] EXT_TEXT [EXT_COUNT] = '{
    TAIL_W'(".c"),   TAIL_W'(".h"),   TAIL_W'(".cc"),  TAIL_W'(".cpp"),
    TAIL_W'(".hpp"), TAIL_W'(".inc"), TAIL_W'(".py"),  TAIL_W'(".js"),
    TAIL_W'(".ts"),  TAIL_W'(".go"),  TAIL_W'(".rs"),  TAIL_W'(".java"),
    TAIL_W'(".rb"),  TAIL_W'(".sh"),  TAIL_W'(".sql")
  };
  localparam int unsigned EXT_LEN [EXT_COUNT] = '{
    2, 2, 3, 4, 4, 4, 3, 3, 3, 3, 3, 5, 3, 3, 4
  };

  typedef enum logic [1:0] {
    REASON_NONE   = 2'd0,
    REASON_TOKEN  = 2'd1,
    REASON_CALLER = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    COLON_NONE = 2'd0,
    COLON_JUST = 2'd1,
    COLON_DONE = 2'd2
  } colon_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } tail_cell_t;

  typedef tail_cell_t [SUFFIX_CHARS-1:0] tail_t;

  // True when the tail, newest byte at index 0, ends in one of the extensions.
  function automatic logic suffix_match(input tail_t tail);
    logic hit;
    logic ok;
    hit = 1'b0;
    for (int i = 0; i < EXT_COUNT; i++) begin
      ok = (EXT_LEN[i] <= SUFFIX_CHARS);
      for (int k = 0; k < SUFFIX_CHARS; k++) begin
        if (k < EXT_LEN[i]) begin
          if (!tail[k].valid || tail[k].data != EXT_TEXT[i][8*k +: 8]) begin
            ok = 1'b0;
          end
        end
      end
      hit = hit | ok;
    end
    return hit;
  endfunction

endpackage

// ===== design/ctsd_if.sv =====
// Valid/ready channel interfaces for query bytes and detector results.
interface ctsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;
  logic       caller_force;

  modport source (output valid, char_code, has_char, last, caller_force, input ready);
  modport sink   (input valid, char_code, has_char, last, caller_force, output ready);
endinterface

interface ctsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reason;
  logic       graph_enable;

  modport source (output valid, reason, graph_enable, input ready);
  modport sink   (input valid, reason, graph_enable, output ready);
endinterface

// ===== design/ctsd_tail_cell.sv =====
// One byte cell of the token tail shift chain.
module ctsd_tail_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                clear,
  input  ctsd_pkg::tail_cell_t up,
  output ctsd_pkg::tail_cell_t held,
  output ctsd_pkg::tail_cell_t look
);

  logic       valid;
  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= up.data;
    end
  end

  assign held.valid = valid;
  assign held.data  = data;

  // View of the cell with the current byte already taken in.
  assign look.valid = shift ? up.valid : valid;
  assign look.data  = shift ? up.data  : data;

endmodule

// ===== design/code_token_shape_detector_core.sv =====
// Top level: token splitter, shape flags, tail cell chain and result register.
//
//   channel | dir | payload                                   | transfer
//   req     | in  | char_code, has_char, last, caller_force   | valid & ready
//   rsp     | out | reason, graph_enable (one per query)      | valid & ready
//
// One query byte per cycle, back to back, while req.ready is high; the result of a
// query appears in the cycle after its last item and sits in an output register.
// The tail is a chain of SUFFIX_CHARS byte cells shifting in every token byte.
// Reset (rst, synchronous) clears all flags, the byte count and the result valid flag.
// req.ready drops only while a result waits and rsp.ready is low.
module code_token_shape_detector_core (
  input  logic            clk,
  input  logic            rst,
  ctsd_in_if.sink         req,
  ctsd_out_if.source      rsp
);

  logic                          in_fire;
  logic                          take;
  logic                          consume;
  logic                          tok_char;
  logic                          tok_sep;
  logic                          is_sep;
  logic                          end_tok;
  logic                          cell_clear;
  logic [7:0]                    c;

  logic                          slash_seen, slash_seen_next;
  logic                          dot_seen, dot_seen_next;
  ctsd_pkg::colon_t              colon_phase, colon_phase_next;
  logic                          token_hit, token_hit_next;
  logic                          query_hit, query_hit_next;
  logic [ctsd_pkg::CHARS_W-1:0]  chars_taken, chars_taken_next;

  logic                          slash_a, dot_a, hit_a, query_a, suffix_hit;
  ctsd_pkg::colon_t              colon_a;
  ctsd_pkg::reason_t             reason_a;

  ctsd_pkg::tail_t               held;
  ctsd_pkg::tail_t               look;
  ctsd_pkg::tail_t               up;

  logic                          out_valid;
  ctsd_pkg::reason_t             out_reason;

  assign req.ready = !out_valid || rsp.ready;
  assign in_fire   = req.valid && req.ready;
  assign c         = req.char_code;

  assign take     = in_fire && req.has_char
                    && (chars_taken < ctsd_pkg::CHARS_W'(ctsd_pkg::MAX_QUERY_CHARS));
  assign consume  = take && (c != ctsd_pkg::CH_NUL);
  assign is_sep   = (c == ctsd_pkg::CH_SPACE) || (c == ctsd_pkg::CH_TAB)
                    || (c == ctsd_pkg::CH_NL);
  assign tok_char = consume && !is_sep;
  assign tok_sep  = consume && is_sep;
  assign end_tok  = tok_sep || (in_fire && req.last);
  assign cell_clear = end_tok;

  // Tail cell chain: cell 0 takes the new byte, the rest take their neighbor.
  assign up[0].valid = 1'b1;
  assign up[0].data  = c;

  for (genvar k = 0; k < ctsd_pkg::SUFFIX_CHARS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign up[k] = held[k-1];
    end
    ctsd_tail_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (tok_char),
      .clear (cell_clear),
      .up    (up[k]),
      .held  (held[k]),
      .look  (look[k])
    );
  end

  // Token flags with the current byte applied.
  always_comb begin
    slash_a = slash_seen || (tok_char && c == ctsd_pkg::CH_SLASH);
    dot_a   = dot_seen   || (tok_char && c == ctsd_pkg::CH_DOT);
    hit_a   = token_hit;
    colon_a = colon_phase;
    if (tok_char) begin
      if (slash_a && dot_a) begin
        hit_a = 1'b1;
      end
      if (held[0].valid && ((held[0].data == ctsd_pkg::CH_COLON && c == ctsd_pkg::CH_COLON)
          || (held[0].data == ctsd_pkg::CH_DASH && c == ctsd_pkg::CH_GT))) begin
        hit_a = 1'b1;
      end
      unique case (colon_phase)
        ctsd_pkg::COLON_NONE: begin
          if (c == ctsd_pkg::CH_COLON) begin
            colon_a = ctsd_pkg::COLON_JUST;
          end
        end
        ctsd_pkg::COLON_JUST: begin
          if (c >= ctsd_pkg::CH_ZERO && c <= ctsd_pkg::CH_NINE) begin
            hit_a = 1'b1;
          end
          colon_a = ctsd_pkg::COLON_DONE;
        end
        ctsd_pkg::COLON_DONE: colon_a = ctsd_pkg::COLON_DONE;
        default:              colon_a = ctsd_pkg::COLON_DONE;
      endcase
    end
  end

  assign suffix_hit = look[0].valid && ctsd_pkg::suffix_match(look);
  assign query_a    = query_hit || (end_tok && (hit_a || suffix_hit));

  always_comb begin
    if (req.caller_force) begin
      reason_a = ctsd_pkg::REASON_CALLER;
    end else if (query_a) begin
      reason_a = ctsd_pkg::REASON_TOKEN;
    end else begin
      reason_a = ctsd_pkg::REASON_NONE;
    end
  end

  always_comb begin
    slash_seen_next  = slash_seen;
    dot_seen_next    = dot_seen;
    colon_phase_next = colon_phase;
    token_hit_next   = token_hit;
    query_hit_next   = query_hit;
    chars_taken_next = chars_taken;
    if (take) begin
      chars_taken_next = consume ? chars_taken + 1'b1
                                 : ctsd_pkg::CHARS_W'(ctsd_pkg::MAX_QUERY_CHARS);
    end
    if (in_fire && req.last) begin
      slash_seen_next  = 1'b0;
      dot_seen_next    = 1'b0;
      colon_phase_next = ctsd_pkg::COLON_NONE;
      token_hit_next   = 1'b0;
      query_hit_next   = 1'b0;
      chars_taken_next = '0;
    end else if (tok_sep) begin
      slash_seen_next  = 1'b0;
      dot_seen_next    = 1'b0;
      colon_phase_next = ctsd_pkg::COLON_NONE;
      token_hit_next   = 1'b0;
      query_hit_next   = query_a;
    end else if (tok_char) begin
      slash_seen_next  = slash_a;
      dot_seen_next    = dot_a;
      colon_phase_next = colon_a;
      token_hit_next   = hit_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slash_seen  <= 1'b0;
      dot_seen    <= 1'b0;
      colon_phase <= ctsd_pkg::COLON_NONE;
      token_hit   <= 1'b0;
      query_hit   <= 1'b0;
      chars_taken <= '0;
    end else begin
      slash_seen  <= slash_seen_next;
      dot_seen    <= dot_seen_next;
      colon_phase <= colon_phase_next;
      token_hit   <= token_hit_next;
      query_hit   <= query_hit_next;
      chars_taken <= chars_taken_next;
    end
  end

  // Result register: load on the last transfer, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && req.last) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && req.last) begin
      out_reason <= reason_a;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.reason       = out_reason;
  assign rsp.graph_enable = (out_reason != ctsd_pkg::REASON_NONE);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    chars_taken <= ctsd_pkg::CHARS_W'(ctsd_pkg::MAX_QUERY_CHARS))
    else $error("byte count past limit");

  a_query_clear: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req.last) |=> (chars_taken == '0 && !query_hit && !held[0].valid))
    else $error("query state not cleared after last transfer");

  a_colon_prev: assert property (@(posedge clk) disable iff (rst)
    (colon_phase == ctsd_pkg::COLON_JUST)
      |-> (held[0].valid && held[0].data == ctsd_pkg::CH_COLON))
    else $error("colon phase without a colon in the tail");

  a_caller_wins: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req.last && req.caller_force)
      |=> (out_valid && out_reason == ctsd_pkg::REASON_CALLER))
    else $error("caller flag did not set the reason");

endmodule
